>>> rtl/pnfe_pkg.sv
package pnfe_pkg;

    localparam int PLACES_DEF      = 16;
    localparam int TRANSITIONS_DEF = 16;
    localparam int TOKEN_BITS_DEF  = 16;
    localparam int MAX_REPORT      = 16;

    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_IN_ARC  = 3'd1;
    localparam logic [2:0] MODE_OUT_ARC = 3'd2;
    localparam logic [2:0] MODE_STEP    = 3'd3;
    localparam logic [2:0] MODE_RESTORE = 3'd4;

    localparam logic [1:0] ST_WRITE_DONE = 2'd0;
    localparam logic [1:0] ST_REPORT     = 2'd1;
    localparam logic [1:0] ST_NONE       = 2'd2;
    localparam logic [1:0] ST_LIMIT      = 2'd3;

    localparam logic REG_ITER_LIMIT = 1'b0;

endpackage

>>> rtl/petri_net_firing_engine.sv
// petri net firing engine
// input channel: in_valid / in_stall carries one item (mode, place_index,
// transition_index, write_value, random_value). output channel: out_valid /
// out_stall carries result items (status, fired_transition, report_place,
// report_tokens, last). iteration_limit is written over the apb port at
// byte address 0; the user must write it only while the block is idle, as
// the block itself does not enforce this. loads, arc writes and restore
// answer one item. restore copies the initial marking one place a cycle.
// a step walks the arc memories one (transition, place) pair a cycle through
// one shared compare/add unit: an enable scan over all pairs, a modulo by
// repeated subtraction (one subtract per cycle), a second scan to find the
// chosen transition, then firing, which updates every place, and then
// min(PLACES,16) report items. the input is stalled for the whole time an
// item is at work. reset clears the control state, counters, the marking
// and the limit; the arc memories are cleared after reset by a sweep of one
// memory entry a cycle, during which input is stalled. when the receiver
// stalls, the result item is held unchanged in the output register until
// taken.
module petri_net_firing_engine #(
    parameter int PLACES      = pnfe_pkg::PLACES_DEF,
    parameter int TRANSITIONS = pnfe_pkg::TRANSITIONS_DEF,
    parameter int TOKEN_BITS  = pnfe_pkg::TOKEN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [3:0]  place_index,
    input  logic [3:0]  transition_index,
    input  logic [15:0] write_value,
    input  logic [15:0] random_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  fired_transition,
    output logic [3:0]  report_place,
    output logic [15:0] report_tokens,
    output logic        last
);

    localparam int PB    = (PLACES > 1) ? $clog2(PLACES) : 1;
    localparam int TB    = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
    localparam int AB    = PB + TB;
    localparam int DEPTH = 1 << AB;
    localparam int CB    = $clog2(TRANSITIONS + 1);
    localparam int NREP  = (PLACES < pnfe_pkg::MAX_REPORT) ? PLACES : pnfe_pkg::MAX_REPORT;
    localparam logic [TOKEN_BITS-1:0] TOK_MAX = {TOKEN_BITS{1'b1}};
    localparam logic [PB-1:0] P_LAST = PB'(PLACES - 1);
    localparam logic [TB-1:0] T_LAST = TB'(TRANSITIONS - 1);
    localparam logic [PB-1:0] R_LAST = PB'(NREP - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RESTORE, S_SCAN, S_SCAN_END, S_MOD,
        S_PICK, S_PICK_END, S_FIRE, S_REPORT, S_OUT
    } state_t;

    // arc memories, one read port each, registered read data
    logic [TOKEN_BITS-1:0] in_arc_mem  [DEPTH];
    logic [TOKEN_BITS-1:0] out_arc_mem [DEPTH];
    logic [TOKEN_BITS-1:0] tok_reg  [PLACES];
    logic [TOKEN_BITS-1:0] init_reg [PLACES];

    state_t state_reg;
    logic [15:0] limit_reg, steps_reg, rnd_reg;
    logic [TB-1:0] t_reg, chosen_reg;
    logic [PB-1:0] p_reg, rd_p_reg;
    logic [AB-1:0] clr_reg;
    logic [CB-1:0] count_reg, pick_reg;
    logic en_reg, arc_reg;           // running enable status of current transition
    logic rd_ok_reg;                 // read data valid for rd_p_reg
    logic rd_last_reg;               // read pair closes a transition
    logic [TOKEN_BITS-1:0] rin_reg, rout_reg;
    logic [1:0]  st_reg;
    logic [3:0]  ft_reg, rp_reg;
    logic [15:0] rt_reg;
    logic        last_reg, ov_reg;

    logic [AB-1:0] rd_addr;
    logic [TOKEN_BITS:0] sum;
    logic [TOKEN_BITS-1:0] diff;

    assign pready = 1'b1;
    assign prdata = {16'd0, limit_reg};
    assign in_stall = (state_reg != S_IDLE) || ov_reg;

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign fired_transition = ft_reg;
    assign report_place = rp_reg;
    assign report_tokens = rt_reg;
    assign last = last_reg;

    // memory read address: transition, place
    always_comb
    begin
        if (state_reg == S_FIRE)
        begin
            rd_addr = AB'({chosen_reg, p_reg});
        end
        else
        begin
            rd_addr = AB'({t_reg, p_reg});
        end
    end

    // shared arithmetic: subtract-then-add with saturation on the read pair
    assign diff = tok_reg[rd_p_reg] - rin_reg;
    assign sum  = {1'b0, diff} + {1'b0, rout_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            in_arc_mem[clr_reg]  <= '0;
            out_arc_mem[clr_reg] <= '0;
        end
        else if (state_reg == S_IDLE && in_valid && !in_stall
                 && 32'(place_index) < PLACES && 32'(transition_index) < TRANSITIONS)
        begin
            if (mode == pnfe_pkg::MODE_IN_ARC)
            begin
                in_arc_mem[AB'({TB'(transition_index), PB'(place_index)})]
                    <= TOKEN_BITS'(write_value);
            end
            if (mode == pnfe_pkg::MODE_OUT_ARC)
            begin
                out_arc_mem[AB'({TB'(transition_index), PB'(place_index)})]
                    <= TOKEN_BITS'(write_value);
            end
        end
        rin_reg  <= in_arc_mem[rd_addr];
        rout_reg <= out_arc_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            limit_reg   <= '0;
            steps_reg   <= '0;
            clr_reg     <= '0;
            t_reg       <= '0;
            p_reg       <= '0;
            rd_p_reg    <= '0;
            chosen_reg  <= '0;
            count_reg   <= '0;
            pick_reg    <= '0;
            rnd_reg     <= '0;
            en_reg      <= 1'b1;
            arc_reg     <= 1'b0;
            rd_ok_reg   <= 1'b0;
            rd_last_reg <= 1'b0;
            ov_reg      <= 1'b0;
            st_reg      <= '0;
            ft_reg      <= '0;
            rp_reg      <= '0;
            rt_reg      <= '0;
            last_reg    <= 1'b0;
            for (int i = 0; i < PLACES; i++)
            begin
                tok_reg[i]  <= '0;
                init_reg[i] <= '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == pnfe_pkg::REG_ITER_LIMIT)
            begin
                limit_reg <= pwdata[15:0];
            end
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            rd_ok_reg   <= 1'b0;
            rd_last_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AB'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        st_reg   <= pnfe_pkg::ST_WRITE_DONE;
                        ft_reg   <= '0;
                        rp_reg   <= '0;
                        rt_reg   <= '0;
                        last_reg <= 1'b1;
                        rnd_reg  <= random_value;
                        t_reg    <= '0;
                        p_reg    <= '0;
                        count_reg <= '0;
                        en_reg   <= 1'b1;
                        arc_reg  <= 1'b0;
                        unique case (mode) inside
                            pnfe_pkg::MODE_LOAD:
                            begin
                                if (32'(place_index) < PLACES)
                                begin
                                    tok_reg[PB'(place_index)]  <= TOKEN_BITS'(write_value);
                                    init_reg[PB'(place_index)] <= TOKEN_BITS'(write_value);
                                end
                                state_reg <= S_OUT;
                            end
                            pnfe_pkg::MODE_IN_ARC, pnfe_pkg::MODE_OUT_ARC:
                            begin
                                state_reg <= S_OUT;
                            end
                            pnfe_pkg::MODE_RESTORE:
                            begin
                                steps_reg <= '0;
                                state_reg <= S_RESTORE;
                            end
                            pnfe_pkg::MODE_STEP:
                            begin
                                if (limit_reg != 16'd0 && steps_reg >= limit_reg)
                                begin
                                    st_reg    <= pnfe_pkg::ST_LIMIT;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    if (steps_reg != 16'hFFFF)
                                    begin
                                        steps_reg <= steps_reg + 16'd1;
                                    end
                                    state_reg <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RESTORE:
                begin
                    tok_reg[p_reg] <= init_reg[p_reg];
                    p_reg <= p_reg + 1'b1;
                    if (p_reg == P_LAST)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN, S_PICK:
                begin
                    // issue reads; evaluate the pair read last cycle
                    rd_p_reg    <= p_reg;
                    rd_ok_reg   <= 1'b1;
                    rd_last_reg <= (p_reg == P_LAST);
                    p_reg <= (p_reg == P_LAST) ? '0 : p_reg + 1'b1;
                    if (p_reg == P_LAST && t_reg == T_LAST)
                    begin
                        state_reg <= (state_reg == S_SCAN) ? S_SCAN_END : S_PICK_END;
                    end
                    if (p_reg == P_LAST)
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // enable evaluation of the pair read last cycle
            if (rd_ok_reg && (state_reg == S_SCAN || state_reg == S_SCAN_END
                              || state_reg == S_PICK || state_reg == S_PICK_END))
            begin
                logic e_n, a_n;
                e_n = en_reg && !(rin_reg != '0 && tok_reg[rd_p_reg] < rin_reg);
                a_n = arc_reg || (rin_reg != '0);
                if (rd_last_reg)
                begin
                    en_reg  <= 1'b1;
                    arc_reg <= 1'b0;
                    if (e_n && a_n)
                    begin
                        if (state_reg == S_SCAN || state_reg == S_SCAN_END)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            if (pick_reg == '0)
                            begin
                                chosen_reg <= t_reg - 1'b1;
                                pick_reg   <= pick_reg - 1'b1;
                            end
                            else if (pick_reg != '1)
                            begin
                                pick_reg <= pick_reg - 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    en_reg  <= e_n;
                    arc_reg <= a_n;
                end
            end

            if (state_reg == S_SCAN_END)
            begin
                state_reg <= S_MOD;
            end
            if (state_reg == S_MOD)
            begin
                // rnd mod count by repeated subtraction
                if (count_reg == '0)
                begin
                    st_reg    <= pnfe_pkg::ST_NONE;
                    state_reg <= S_OUT;
                end
                else if (rnd_reg >= 16'(count_reg))
                begin
                    rnd_reg <= rnd_reg - 16'(count_reg);
                end
                else
                begin
                    pick_reg  <= CB'(rnd_reg);
                    t_reg     <= '0;
                    p_reg     <= '0;
                    state_reg <= S_PICK;
                end
            end
            if (state_reg == S_PICK_END)
            begin
                p_reg     <= '0;
                state_reg <= S_FIRE;
            end
            if (state_reg == S_FIRE)
            begin
                rd_p_reg  <= p_reg;
                rd_ok_reg <= 1'b1;
                p_reg     <= (p_reg == P_LAST) ? '0 : p_reg + 1'b1;
                if (rd_ok_reg)
                begin
                    tok_reg[rd_p_reg] <= sum[TOKEN_BITS] ? TOK_MAX : sum[TOKEN_BITS-1:0];
                    if (rd_p_reg == P_LAST)
                    begin
                        rd_ok_reg <= 1'b0;
                        p_reg     <= '0;
                        state_reg <= S_REPORT;
                    end
                end
            end
            if (state_reg == S_REPORT && (!ov_reg || !out_stall))
            begin
                ov_reg   <= 1'b1;
                st_reg   <= pnfe_pkg::ST_REPORT;
                ft_reg   <= 4'(chosen_reg);
                rp_reg   <= 4'(p_reg);
                rt_reg   <= 16'(tok_reg[p_reg]);
                last_reg <= (p_reg == R_LAST);
                p_reg    <= p_reg + 1'b1;
                if (p_reg == R_LAST)
                begin
                    state_reg <= S_IDLE;
                end
            end
            if (state_reg == S_OUT)
            begin
                ft_reg    <= '0;
                rp_reg    <= '0;
                rt_reg    <= '0;
                last_reg  <= 1'b1;
                ov_reg    <= 1'b1;
                state_reg <= S_IDLE;
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(report_tokens) && $stable(status)))
        else $error("stalled result changed");
    a_report_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == pnfe_pkg::ST_REPORT && last) |-> (report_place == 4'(R_LAST)))
        else $error("report ended on wrong place");

endmodule
